// ----- sv/hmac_pkg.sv -----
// ----------------------------------------------------------------------------
// hmac_pkg: shared types and constants for the HMAC-SHA256 engine
// Transfer payloads, opcodes, controller/datapath command and status
// structs, and the SHA-256 constant tables.
// ----------------------------------------------------------------------------
`default_nettype none

package hmac_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int BLOCK_WORDS = BLOCK_BYTES / 4;

  // Input opcodes
  localparam logic [1:0] OP_KEY_BYTE = 2'd0;
  localparam logic [1:0] OP_KEY_END  = 2'd1;
  localparam logic [1:0] OP_MSG_BYTE = 2'd2;
  localparam logic [1:0] OP_MSG_END  = 2'd3;

  // Compression block sources
  localparam logic [1:0] SRC_KEY  = 2'd0;
  localparam logic [1:0] SRC_IPAD = 2'd1;
  localparam logic [1:0] SRC_OPAD = 2'd2;
  localparam logic [1:0] SRC_BUF  = 2'd3;

  // Finishing jobs (which hash is being padded)
  localparam logic [1:0] JOB_KEY   = 2'd0;
  localparam logic [1:0] JOB_INNER = 2'd1;
  localparam logic [1:0] JOB_OUTER = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  typedef struct packed {
    logic       key_wr;
    logic       key_restart;
    logic       key_clr;
    logic       msg_wr;
    logic       len_clr;
    logic       pad;
    logic       buf_clr;
    logic       len_wr;
    logic       key_from_chain;
    logic       save_inner;
    logic       buf_from_inner;
    logic       comp_start;
    logic       comp_init;
    logic [1:0] comp_src;
    logic [1:0] job;
    logic [2:0] out_idx;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic len_eq_blk;
    logic len_gt_blk;
    logic idx_last;
    logic fill_ge56;
  } sts_t;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

`default_nettype wire

// ----- sv/hmac_sha256_engine_core.sv -----
// A key or message byte that fills a block adds one compression (start,
// 64 rounds, chaining add, done). From end of message to the first digest
// word: 3 to 4 compressions, then one word per cycle while the sink is ready.
// One item is worked at a time; the compression unit sets the rate.
// Reset: asynchronous, active low; the engine returns to idle awaiting a key.
// ----------------------------------------------------------------------------
// hmac_sha256_engine_core: streaming HMAC-SHA256 engine
// Takes key and message bytes over a valid/ready channel and emits the
// 256-bit MAC as eight 32-bit big-endian words.
// ----------------------------------------------------------------------------
`default_nettype none

module hmac_sha256_engine_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire hmac_pkg::in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output hmac_pkg::out_t     out_data_o
);
  import hmac_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] digest_word;

  hmac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .opcode_i    (in_data_i.opcode),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hmac_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (in_data_i.data_byte),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .digest_word_o (digest_word)
  );

  // Drive the result word
  assign out_data_o.digest_word = digest_word;
  assign out_data_o.word_index  = cmd.out_idx;
  assign out_data_o.last_word   = (cmd.out_idx == 3'd7);

endmodule

`default_nettype wire

// ----- sv/hmac_ctrl.sv -----
// ----------------------------------------------------------------------------
// hmac_ctrl: sequencing state machine
// Decodes opcodes, steps the datapath through key hashing, padding and
// the inner/outer hashes, and walks the eight digest words out.
// ----------------------------------------------------------------------------
`default_nettype none

module hmac_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [1:0]    opcode_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire hmac_pkg::sts_t sts_i,
  output hmac_pkg::cmd_t     cmd_o
);
  import hmac_pkg::*;

  localparam logic [3:0] S_IN    = 4'd0;
  localparam logic [3:0] S_WAIT  = 4'd1;
  localparam logic [3:0] S_KHASH = 4'd2;
  localparam logic [3:0] S_CBUF  = 4'd3;
  localparam logic [3:0] S_PAD   = 4'd4;
  localparam logic [3:0] S_PADC  = 4'd5;
  localparam logic [3:0] S_BCLR  = 4'd6;
  localparam logic [3:0] S_LEN   = 4'd7;
  localparam logic [3:0] S_FCMP  = 4'd8;
  localparam logic [3:0] S_FDONE = 4'd9;
  localparam logic [3:0] S_IPAD  = 4'd10;
  localparam logic [3:0] S_OPAD  = 4'd11;
  localparam logic [3:0] S_OBUF  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_KEY  = 2'd1;
  localparam logic [1:0] PH_MSG  = 2'd2;

  logic [3:0] state_q, state_d, ret_q, ret_d;
  logic [1:0] phase_q, phase_d, job_q, job_d;
  logic [2:0] idx_q, idx_d;
  logic       in_xfer;

  assign in_ready_o  = (state_q == S_IN);
  assign out_valid_o = (state_q == S_OUT);
  assign in_xfer     = in_valid_i && in_ready_o;

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    phase_d = phase_q;
    job_d   = job_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.job     = job_q;
    cmd_o.out_idx = idx_q;
    unique case (state_q)
      S_IN: begin
        if (in_xfer) begin
          unique case (opcode_i)
            OP_KEY_BYTE: begin
              cmd_o.key_wr      = 1'b1;
              cmd_o.key_restart = (phase_q != PH_KEY);
              phase_d           = PH_KEY;
              if (phase_q == PH_KEY && sts_i.len_eq_blk) begin
                state_d = S_KHASH;
              end else if (phase_q == PH_KEY && sts_i.len_gt_blk && sts_i.idx_last) begin
                state_d = S_CBUF;
              end
            end
            OP_KEY_END: begin
              if (phase_q != PH_KEY) begin
                cmd_o.key_clr = 1'b1;
                state_d       = S_IPAD;
              end else if (sts_i.len_gt_blk) begin
                job_d   = JOB_KEY;
                state_d = S_PAD;
              end else begin
                state_d = S_IPAD;
              end
            end
            OP_MSG_BYTE: begin
              if (phase_q == PH_MSG) begin
                cmd_o.msg_wr = 1'b1;
                if (sts_i.idx_last) state_d = S_CBUF;
              end
            end
            OP_MSG_END: begin
              if (phase_q == PH_MSG) begin
                job_d   = JOB_INNER;
                state_d = S_PAD;
              end
            end
            default: ;
          endcase
        end
      end
      S_WAIT: begin
        if (!sts_i.busy) state_d = ret_q;
      end
      S_KHASH: begin
        cmd_o.comp_start = 1'b1;
        cmd_o.comp_init  = 1'b1;
        cmd_o.comp_src   = SRC_KEY;
        ret_d            = S_IN;
        state_d          = S_WAIT;
      end
      S_CBUF: begin
        cmd_o.comp_start = 1'b1;
        cmd_o.comp_src   = SRC_BUF;
        ret_d            = S_IN;
        state_d          = S_WAIT;
      end
      S_PAD: begin
        cmd_o.pad = 1'b1;
        state_d   = sts_i.fill_ge56 ? S_PADC : S_LEN;
      end
      S_PADC: begin
        cmd_o.comp_start = 1'b1;
        cmd_o.comp_src   = SRC_BUF;
        ret_d            = S_BCLR;
        state_d          = S_WAIT;
      end
      S_BCLR: begin
        cmd_o.buf_clr = 1'b1;
        state_d       = S_LEN;
      end
      S_LEN: begin
        cmd_o.len_wr = 1'b1;
        state_d      = S_FCMP;
      end
      S_FCMP: begin
        cmd_o.comp_start = 1'b1;
        cmd_o.comp_src   = SRC_BUF;
        ret_d            = S_FDONE;
        state_d          = S_WAIT;
      end
      S_FDONE: begin
        priority case (job_q)
          JOB_KEY: begin
            cmd_o.key_from_chain = 1'b1;
            state_d              = S_IPAD;
          end
          JOB_INNER: begin
            cmd_o.save_inner = 1'b1;
            state_d          = S_OPAD;
          end
          default: state_d = S_OUT;
        endcase
      end
      S_IPAD: begin
        cmd_o.comp_start = 1'b1;
        cmd_o.comp_init  = 1'b1;
        cmd_o.comp_src   = SRC_IPAD;
        cmd_o.len_clr    = 1'b1;
        phase_d          = PH_MSG;
        ret_d            = S_IN;
        state_d          = S_WAIT;
      end
      S_OPAD: begin
        cmd_o.comp_start = 1'b1;
        cmd_o.comp_init  = 1'b1;
        cmd_o.comp_src   = SRC_OPAD;
        ret_d            = S_OBUF;
        state_d          = S_WAIT;
      end
      S_OBUF: begin
        cmd_o.buf_from_inner = 1'b1;
        job_d                = JOB_OUTER;
        state_d              = S_PAD;
      end
      S_OUT: begin
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            phase_d = PH_IDLE;
            state_d = S_IN;
          end
        end
      end
      default: state_d = S_IN;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IN;
      ret_q   <= S_IN;
      phase_q <= PH_IDLE;
      job_q   <= JOB_KEY;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      phase_q <= phase_d;
      job_q   <= job_d;
      idx_q   <= idx_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/hmac_dp.sv -----
// ----------------------------------------------------------------------------
// hmac_dp: HMAC-SHA256 datapath
// Key and block buffers, length counter, padding logic and an iterative
// SHA-256 compression unit (one round per cycle, then a final chaining add).
// ----------------------------------------------------------------------------
`default_nettype none

module hmac_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [7:0]     data_byte_i,
  input  wire hmac_pkg::cmd_t cmd_i,
  output hmac_pkg::sts_t      sts_o,
  output logic [31:0]         digest_word_o
);
  import hmac_pkg::*;

  logic [31:0] key_q   [BLOCK_WORDS];
  logic [31:0] buf_q   [BLOCK_WORDS];
  logic [31:0] w_q     [BLOCK_WORDS];
  logic [31:0] src_w   [BLOCK_WORDS];
  logic [31:0] chain_q [8];
  logic [31:0] inner_q [8];
  logic [31:0] st_q    [8];
  logic [63:0] len_q;
  logic [6:0]  cnt_q;
  logic        busy_q;

  logic [5:0]  fill;
  logic [63:0] tot_bytes, tot_bits;
  logic [3:0]  wr_word;
  logic [4:0]  wr_sh;
  logic        buf_key_wr;
  logic [31:0] t1, t2, w_new, s0, s1, ch, maj, big0, big1;

  // Padding position and total length for the hash being finished
  assign fill = (cmd_i.job == JOB_OUTER) ? 6'd32 : len_q[5:0];
  always_comb begin
    priority case (cmd_i.job)
      JOB_OUTER: tot_bytes = 64'd96;
      JOB_INNER: tot_bytes = len_q + 64'd64;
      default:   tot_bytes = len_q;
    endcase
  end
  assign tot_bits = {tot_bytes[60:0], 3'b000};

  assign wr_word    = len_q[5:2];
  assign wr_sh      = {~len_q[1:0], 3'b000};
  assign buf_key_wr = cmd_i.key_wr && !cmd_i.key_restart && (len_q >= 64'(BLOCK_BYTES));

  assign sts_o.busy       = busy_q;
  assign sts_o.len_eq_blk = (len_q == 64'(BLOCK_BYTES));
  assign sts_o.len_gt_blk = (len_q > 64'(BLOCK_BYTES));
  assign sts_o.idx_last   = (len_q[5:0] == 6'h3f);
  assign sts_o.fill_ge56  = (fill >= 6'd56);

  assign digest_word_o = chain_q[cmd_i.out_idx];

  // Key store: clear for an empty key, restart with the first key byte, fill byte by byte, or take the key hash
  always_ff @(posedge clk_i) begin
    if (cmd_i.key_clr) begin
      for (int i = 0; i < BLOCK_WORDS; i++) key_q[i] <= '0;
    end else if (cmd_i.key_wr && cmd_i.key_restart) begin
      key_q[0] <= {data_byte_i, 24'h000000};
      for (int i = 1; i < BLOCK_WORDS; i++) key_q[i] <= '0;
    end else if (cmd_i.key_from_chain) begin
      for (int i = 0; i < BLOCK_WORDS; i++) key_q[i] <= (i < 8) ? chain_q[i[2:0]] : '0;
    end else if (cmd_i.key_wr && (len_q < 64'(BLOCK_BYTES))) begin
      key_q[wr_word][wr_sh +: 8] <= data_byte_i;
    end
  end

  // Block buffer: byte writes, padding, clear, length words, outer message
  always_ff @(posedge clk_i) begin
    if (cmd_i.msg_wr || buf_key_wr) begin
      buf_q[wr_word][wr_sh +: 8] <= data_byte_i;
    end
    if (cmd_i.pad) begin
      for (int i = 0; i < BLOCK_WORDS; i++) begin
        for (int j = 0; j < 4; j++) begin
          if (6'(i * 4 + j) == fill) begin
            buf_q[i][(3 - j) * 8 +: 8] <= 8'h80;
          end else if (6'(i * 4 + j) > fill) begin
            buf_q[i][(3 - j) * 8 +: 8] <= 8'h00;
          end
        end
      end
    end
    if (cmd_i.buf_clr) begin
      for (int i = 0; i < BLOCK_WORDS; i++) buf_q[i] <= '0;
    end
    if (cmd_i.len_wr) begin
      buf_q[BLOCK_WORDS - 2] <= tot_bits[63:32];
      buf_q[BLOCK_WORDS - 1] <= tot_bits[31:0];
    end
    if (cmd_i.buf_from_inner) begin
      for (int i = 0; i < 8; i++) buf_q[i] <= inner_q[i];
    end
  end

  // Save the inner digest
  always_ff @(posedge clk_i) begin
    if (cmd_i.save_inner) begin
      for (int i = 0; i < 8; i++) inner_q[i] <= chain_q[i];
    end
  end

  // Byte counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cmd_i.len_clr || cmd_i.key_clr) begin
      len_q <= '0;
    end else if (cmd_i.key_wr && cmd_i.key_restart) begin
      len_q <= 64'd1;
    end else if (cmd_i.key_wr || cmd_i.msg_wr) begin
      len_q <= len_q + 64'd1;
    end
  end

  // Select the block to compress
  always_comb begin
    for (int i = 0; i < BLOCK_WORDS; i++) begin
      unique case (cmd_i.comp_src)
        SRC_KEY:  src_w[i] = key_q[i];
        SRC_IPAD: src_w[i] = key_q[i] ^ 32'h36363636;
        SRC_OPAD: src_w[i] = key_q[i] ^ 32'h5c5c5c5c;
        default:  src_w[i] = buf_q[i];
      endcase
    end
  end

  // One SHA-256 round and the message schedule step
  always_comb begin
    big1  = {st_q[4][5:0], st_q[4][31:6]} ^ {st_q[4][10:0], st_q[4][31:11]}
          ^ {st_q[4][24:0], st_q[4][31:25]};
    ch    = (st_q[4] & st_q[5]) ^ (~st_q[4] & st_q[6]);
    t1    = st_q[7] + big1 + ch + SHA_K[cnt_q[5:0]] + w_q[0];
    big0  = {st_q[0][1:0], st_q[0][31:2]} ^ {st_q[0][12:0], st_q[0][31:13]}
          ^ {st_q[0][21:0], st_q[0][31:22]};
    maj   = (st_q[0] & st_q[1]) ^ (st_q[0] & st_q[2]) ^ (st_q[1] & st_q[2]);
    t2    = big0 + maj;
    s0    = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
    s1    = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
          ^ (w_q[14] >> 10);
    w_new = w_q[0] + s0 + w_q[9] + s1;
  end

  // Round counter: 64 rounds, then the chaining add
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.comp_start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q[6]) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 7'd1;
      end
    end
  end

  // Working variables, schedule window and chaining value
  always_ff @(posedge clk_i) begin
    if (cmd_i.comp_start) begin
      for (int i = 0; i < BLOCK_WORDS; i++) w_q[i] <= src_w[i];
      for (int i = 0; i < 8; i++) begin
        if (cmd_i.comp_init) begin
          chain_q[i] <= SHA_IV[i];
          st_q[i]    <= SHA_IV[i];
        end else begin
          st_q[i] <= chain_q[i];
        end
      end
    end else if (busy_q) begin
      if (cnt_q[6]) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + st_q[i];
      end else begin
        st_q[0] <= t1 + t2;
        st_q[1] <= st_q[0];
        st_q[2] <= st_q[1];
        st_q[3] <= st_q[2];
        st_q[4] <= st_q[3] + t1;
        st_q[5] <= st_q[4];
        st_q[6] <= st_q[5];
        st_q[7] <= st_q[6];
        for (int i = 0; i < BLOCK_WORDS - 1; i++) w_q[i] <= w_q[i + 1];
        w_q[BLOCK_WORDS - 1] <= w_new;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/hmac_checker.sv -----
// ----------------------------------------------------------------------------
// hmac_checker: port-level checks for the HMAC-SHA256 engine
// Watches the transfer handshakes and the digest word sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module hmac_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire hmac_pkg::out_t out_data_o
);
  import hmac_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Never take input while the digest is draining
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready during digest output");

  // Advance the word index by one per transfer
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_word |=>
      out_valid_o && (out_data_o.word_index == $past(out_data_o.word_index) + 3'd1))
    else $error("digest word skipped");

  // Drop valid after the last word
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.last_word |=> !out_valid_o && in_ready_o)
    else $error("output continued past last word");

endmodule

bind hmac_sha256_engine_core hmac_checker u_hmac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
